### rtl/nor_flash_command_interface_assert.svh
// Assertion macros for the NOR flash command interface.
// Clocked assertion forms, with and without a reset that disables them.
`ifndef NOR_FLASH_COMMAND_INTERFACE_ASSERT_SVH
`define NOR_FLASH_COMMAND_INTERFACE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked at every clock edge outside reset.
`define NFCI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define NFCI_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NFCI_ASSERT(lbl, clk, rst, prop, msg)
`define NFCI_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

### rtl/nfci_pkg.sv
// Constants of the NOR flash command interface: command codes, status bytes,
// fault codes and the CFI query table. No dependencies.
package nfci_pkg;

  // Array geometry.
  localparam int ARRAY_AW    = 16;
  localparam int ARRAY_DEPTH = 65536;

  // Command bytes.
  localparam logic [7:0] CMD_READ_ARRAY = 8'hFF;
  localparam logic [7:0] CMD_READ_ID    = 8'h90;
  localparam logic [7:0] CMD_CFI_QUERY  = 8'h98;
  localparam logic [7:0] CMD_READ_SR    = 8'h70;
  localparam logic [7:0] CMD_CLEAR_SR   = 8'h50;
  localparam logic [7:0] CMD_PROGRAM    = 8'h40;
  localparam logic [7:0] CMD_PROGRAM_A  = 8'h10;
  localparam logic [7:0] CMD_ERASE      = 8'h20;
  localparam logic [7:0] CMD_LOCK       = 8'h60;
  localparam logic [7:0] CMD_SUSPEND    = 8'hB0;
  localparam logic [7:0] CMD_CONFIRM    = 8'hD0;
  localparam logic [7:0] CMD_LOCK_SET   = 8'h01;

  // Status register values.
  localparam logic [7:0] SR_READY        = 8'h80;
  localparam logic [7:0] SR_PROG_LOCKED  = 8'h92;
  localparam logic [7:0] SR_ERASE_LOCKED = 8'hA2;

  // Fault codes.
  localparam logic [1:0] FAULT_OK    = 2'd0;
  localparam logic [1:0] FAULT_CMD   = 2'd1;
  localparam logic [1:0] FAULT_RANGE = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_MANUFACTURER = 1'b0;
  localparam logic CFG_DEVICE       = 1'b1;

  // CFI query table window.
  localparam logic [15:0] CFI_BASE = 16'h0010;
  localparam logic [15:0] CFI_END  = 16'h003F;

  // CFI query table, indexed from the start of the window.
  function automatic logic [7:0] cfi_byte(input logic [5:0] idx);
    logic [7:0] b;
    case (idx)
      6'd0:  b = 8'h51;  6'd1:  b = 8'h52;  6'd2:  b = 8'h59;  6'd3:  b = 8'h01;
      6'd4:  b = 8'h00;  6'd5:  b = 8'h31;  6'd6:  b = 8'h00;  6'd7:  b = 8'h00;
      6'd8:  b = 8'h00;  6'd9:  b = 8'h00;  6'd10: b = 8'h00;  6'd11: b = 8'h27;
      6'd12: b = 8'h36;  6'd13: b = 8'h00;  6'd14: b = 8'h00;  6'd15: b = 8'h07;
      6'd16: b = 8'h07;  6'd17: b = 8'h0A;  6'd18: b = 8'h00;  6'd19: b = 8'h04;
      6'd20: b = 8'h04;  6'd21: b = 8'h04;  6'd22: b = 8'h00;  6'd23: b = 8'h18;
      6'd24: b = 8'h02;  6'd25: b = 8'h00;  6'd26: b = 8'h05;  6'd27: b = 8'h00;
      6'd28: b = 8'h01;  6'd29: b = 8'h7F;  6'd30: b = 8'h00;  6'd31: b = 8'h00;
      6'd32: b = 8'h02;  6'd33: b = 8'h50;  6'd34: b = 8'h52;  6'd35: b = 8'h49;
      6'd36: b = 8'h31;  6'd37: b = 8'h31;  6'd38: b = 8'h0A;  6'd39: b = 8'h00;
      6'd40: b = 8'h00;  6'd41: b = 8'h00;  6'd42: b = 8'h01;  6'd43: b = 8'h01;
      6'd44: b = 8'h00;  6'd45: b = 8'h33;  6'd46: b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/nfci_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module nfci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read port whose data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/nor_flash_command_interface.sv
// NOR flash command interface: one x8 chip with command decoding and array.
// Read: S_MUL1, S_MUL2, S_REM and S_RBYTE per byte (shared multiplier for the
// block index, RAM read), then S_DONE; a write decodes up to S_WDEC, program
// adds S_PRD and S_PWR per byte, erase walks its block in S_ERASE, S_IDLE sits
// between items. The result register frees the input side. After reset a pass
// writes 0xFF to every cell with s_tready low; configuration writes go through.
module nor_flash_command_interface
  import nfci_pkg::*;
#(
  parameter int BLOCK_BYTES = 4096,
  parameter int BLOCK_COUNT = 16,
  parameter int LOCK_OFFSET = 2
) (
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // address[15:0], data[47:16], width_bytes[50:48]
  input  logic        s_tuser,   // action (0 read, 1 write)
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_data[31:0], fault[33:32]
  // Configuration writes.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

`include "nor_flash_command_interface_assert.svh"

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BLOCK_BYTES);
  localparam int BLK_MAX = (ARRAY_DEPTH - 1) / BLOCK_BYTES;
  localparam int BLK_W   = BLK_MAX > 0 ? $clog2(BLK_MAX + 1) : 1;
  localparam int LK_W    = BLOCK_COUNT > 1 ? $clog2(BLOCK_COUNT) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL1, S_MUL2, S_REM, S_RBYTE, S_WDEC,
    S_PRD, S_PWR, S_ERASE, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_ARRAY, MODE_PROGRAM, MODE_ERASE, MODE_LOCK
  } mode_t;

  typedef enum logic [1:0] {
    VIEW_PLAIN, VIEW_STATUS, VIEW_ID, VIEW_CFI
  } view_t;

  state_t     state;
  mode_t      command_mode;
  view_t      view_kind;
  logic [15:0] status_location;
  logic [7:0]  status_value;
  logic [BLOCK_COUNT-1:0] block_lock;
  logic [7:0]  manufacturer_code;
  logic [7:0]  device_code;

  // Item registers.
  logic        action_r;
  logic [15:0] cur_addr;
  logic [31:0] data_r;
  logic [2:0]  n_r;
  logic [2:0]  cnt;
  logic [31:0] rd_acc;
  logic [1:0]  fault_r;

  // Block index unit.
  logic [15:0]      op_a;
  logic [31:0]      op_b;
  logic [47:0]      mul_out;
  logic [47:0]      prod;
  logic [BLK_W-1:0] est;
  logic [BLK_W-1:0] blk;
  logic [15:0]      rem;
  logic [15:0]      rem0;
  logic             rem_ge;

  // Erase and clearing walk.
  logic [16:0] erase_ptr;
  logic [16:0] erase_end;
  logic [15:0] erase_base;
  logic [31:0] erase_top;

  // Cell array ports.
  logic        ram_we;
  logic [15:0] ram_waddr;
  logic [7:0]  ram_wdata;
  logic        ram_re;
  logic [15:0] ram_raddr;
  logic [7:0]  ram_rdata;

  logic [2:0]  n_in;
  logic [31:0] din_masked;
  logic [7:0]  cmd;
  logic [31:0] blk_ext;
  logic [LK_W-1:0] lk_idx;
  logic        blk_ok;
  logic        blk_locked;
  logic [7:0]  view_byte;
  logic [15:0] prog_addr;
  logic [7:0]  prog_byte;

  assign s_tready = (state == S_IDLE);

  // Width clamp and masking of the data bytes above the access width.
  always_comb begin
    n_in = (s_tdata[50:48] > 3'd4) ? 3'd4 : s_tdata[50:48];
    for (int k = 0; k < 4; k++) begin
      din_masked[8*k +: 8] = (3'(k) < n_in) ? s_tdata[16 + 8*k +: 8] : 8'h00;
    end
  end

  // Shared multiplier: address times reciprocal, then estimate times block size.
  always_comb begin
    if (state == S_MUL2) begin
      op_a = 16'(prod[32 +: BLK_W]);
      op_b = 32'(BLOCK_BYTES);
    end else begin
      op_a = cur_addr;
      op_b = RECIP;
    end
  end
  assign mul_out = op_a * op_b;

  // Remainder and one-step correction of the block estimate.
  assign rem0   = cur_addr - prod[15:0];
  assign rem_ge = 32'(rem0) >= 32'(BLOCK_BYTES);

  // Block checks for the registered block index.
  assign blk_ext    = 32'(blk);
  assign lk_idx     = blk_ext[LK_W-1:0];
  assign blk_ok     = blk_ext < 32'(BLOCK_COUNT);
  assign blk_locked = blk_ok && block_lock[lk_idx];
  assign cmd        = data_r[7:0];

  // Erase range: from the block base up to its end, clipped at the array top.
  assign erase_base = cur_addr - rem;
  assign erase_top  = 32'(erase_base) + 32'(BLOCK_BYTES);

  // Program address and data byte.
  assign prog_addr = cur_addr + 16'(cnt);
  assign prog_byte = data_r[{cnt[1:0], 3'b000} +: 8];

  // Byte presented by the current view, else the array byte.
  always_comb begin
    view_byte = ram_rdata;
    case (view_kind)
      VIEW_STATUS: begin
        if (cur_addr == status_location) view_byte = status_value;
      end
      VIEW_ID: begin
        if (cur_addr == 16'd0) begin
          view_byte = manufacturer_code;
        end else if (cur_addr == 16'd1) begin
          view_byte = device_code;
        end else if (blk_ok && 32'(rem) == 32'(LOCK_OFFSET)) begin
          view_byte = {7'd0, block_lock[lk_idx]};
        end
      end
      VIEW_CFI: begin
        if (cur_addr >= CFI_BASE && cur_addr < CFI_END) begin
          view_byte = cfi_byte(6'(cur_addr - CFI_BASE));
        end
      end
      default: view_byte = ram_rdata;
    endcase
  end

  // Cell array port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = erase_ptr[15:0];
    ram_wdata = 8'hFF;
    ram_re    = 1'b0;
    ram_raddr = cur_addr;
    case (state)
      S_CLEAR, S_ERASE: ram_we = 1'b1;
      S_PWR: begin
        ram_we    = 1'b1;
        ram_waddr = prog_addr;
        ram_wdata = ram_rdata & prog_byte;
      end
      S_MUL1: ram_re = 1'b1;
      S_PRD: begin
        ram_re    = 1'b1;
        ram_raddr = prog_addr;
      end
      default: ram_re = 1'b0;
    endcase
  end

  nfci_ram #(
    .WIDTH(8),
    .DEPTH(ARRAY_DEPTH)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      manufacturer_code <= 8'h89;
      device_code       <= 8'h18;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MANUFACTURER: manufacturer_code <= cfg_data;
        CFG_DEVICE:       device_code       <= cfg_data;
        default:          device_code       <= device_code;
      endcase
    end
  end

  // Sequencer, command state and result register.
  always_ff @(posedge clk) begin
    prod <= mul_out;
    if (rst) begin
      state           <= S_CLEAR;
      command_mode    <= MODE_ARRAY;
      view_kind       <= VIEW_PLAIN;
      status_location <= 16'd0;
      status_value    <= SR_READY;
      block_lock      <= '0;
      erase_ptr       <= 17'd0;
      m_tvalid        <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          erase_ptr <= erase_ptr + 17'd1;
          if (erase_ptr[15:0] == 16'hFFFF) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            action_r <= s_tuser;
            cur_addr <= s_tdata[15:0];
            data_r   <= din_masked;
            n_r      <= n_in;
            cnt      <= 3'd0;
            rd_acc   <= 32'd0;
            fault_r  <= FAULT_OK;
            state    <= (!s_tuser && n_in == 3'd0) ? S_DONE : S_MUL1;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: begin
          est   <= prod[32 +: BLK_W];
          state <= S_REM;
        end
        S_REM: begin
          blk   <= rem_ge ? est + BLK_W'(1) : est;
          rem   <= rem_ge ? rem0 - 16'(BLOCK_BYTES) : rem0;
          state <= action_r ? S_WDEC : S_RBYTE;
        end
        S_RBYTE: begin
          rd_acc[{cnt[1:0], 3'b000} +: 8] <= view_byte;
          if (cnt + 3'd1 == n_r) begin
            state <= S_DONE;
          end else begin
            cnt      <= cnt + 3'd1;
            cur_addr <= cur_addr + 16'd1;
            state    <= S_MUL1;
          end
        end
        S_WDEC: begin
          state <= S_DONE;
          case (command_mode)
            MODE_PROGRAM: begin
              command_mode <= MODE_ARRAY;
              if (!blk_ok) begin
                fault_r <= FAULT_RANGE;
              end else if (blk_locked) begin
                view_kind       <= VIEW_STATUS;
                status_location <= cur_addr;
                status_value    <= SR_PROG_LOCKED;
              end else if (n_r == 3'd0) begin
                view_kind       <= VIEW_STATUS;
                status_location <= cur_addr;
                status_value    <= SR_READY;
              end else begin
                state <= S_PRD;
              end
            end
            MODE_ERASE: begin
              command_mode <= MODE_ARRAY;
              if (cmd == CMD_CONFIRM) begin
                if (!blk_ok) begin
                  fault_r <= FAULT_RANGE;
                end else if (blk_locked) begin
                  view_kind       <= VIEW_STATUS;
                  status_location <= cur_addr;
                  status_value    <= SR_ERASE_LOCKED;
                end else begin
                  erase_ptr <= {1'b0, erase_base};
                  erase_end <= (erase_top > 32'(ARRAY_DEPTH)) ? 17'(ARRAY_DEPTH)
                                                              : erase_top[16:0];
                  state     <= S_ERASE;
                end
              end
            end
            MODE_LOCK: begin
              command_mode <= MODE_ARRAY;
              if (cmd == CMD_LOCK_SET) begin
                if (!blk_ok) begin
                  fault_r <= FAULT_RANGE;
                end else begin
                  block_lock[lk_idx] <= 1'b1;
                  view_kind          <= VIEW_STATUS;
                  status_location    <= cur_addr;
                  status_value       <= SR_READY;
                end
              end else if (cmd == CMD_CONFIRM) begin
                block_lock      <= '0;
                view_kind       <= VIEW_STATUS;
                status_location <= cur_addr;
                status_value    <= SR_READY;
              end else begin
                view_kind <= VIEW_PLAIN;
              end
            end
            default: begin
              case (cmd)
                CMD_READ_ARRAY: view_kind <= VIEW_PLAIN;
                CMD_READ_ID:    view_kind <= VIEW_ID;
                CMD_CFI_QUERY:  view_kind <= VIEW_CFI;
                CMD_READ_SR: begin
                  view_kind       <= VIEW_STATUS;
                  status_location <= cur_addr;
                  status_value    <= SR_READY;
                end
                CMD_CLEAR_SR, CMD_SUSPEND, CMD_CONFIRM: fault_r <= FAULT_OK;
                CMD_PROGRAM, CMD_PROGRAM_A: command_mode <= MODE_PROGRAM;
                CMD_ERASE: command_mode <= MODE_ERASE;
                CMD_LOCK: begin
                  command_mode    <= MODE_LOCK;
                  view_kind       <= VIEW_STATUS;
                  status_location <= cur_addr;
                  status_value    <= SR_READY;
                end
                default: fault_r <= FAULT_CMD;
              endcase
            end
          endcase
        end
        S_PRD: state <= S_PWR;
        S_PWR: begin
          if (cnt + 3'd1 == n_r) begin
            view_kind       <= VIEW_STATUS;
            status_location <= cur_addr;
            status_value    <= SR_READY;
            state           <= S_DONE;
          end else begin
            cnt   <= cnt + 3'd1;
            state <= S_PRD;
          end
        end
        S_ERASE: begin
          erase_ptr <= erase_ptr + 17'd1;
          if (erase_ptr + 17'd1 == erase_end) begin
            view_kind       <= VIEW_STATUS;
            status_location <= cur_addr;
            status_value    <= SR_READY;
            state           <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, fault_r, rd_acc};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  `NFCI_ASSERT_NORST(a_reset_quiet, clk, rst |=> !s_tready && !m_tvalid, "reset left a handshake open")
  `NFCI_ASSERT(a_one_item, clk, rst, s_tvalid && s_tready |=> !s_tready, "second item taken while busy")
  `NFCI_ASSERT(a_erase_bound, clk, rst, state == S_ERASE |-> erase_ptr < erase_end, "erase walk overran its block")
  `NFCI_ASSERT(a_byte_bound, clk, rst, state == S_RBYTE |-> cnt < n_r, "read byte count beyond access width")

endmodule

### tb/sv/tb_nor_flash_command_interface.sv
// Self-checking testbench for the NOR flash command interface: directed and random bus accesses.
// Expected replies come from a flash model kept inside this file.
// Depends on nfci_pkg and nor_flash_command_interface.
module tb_nor_flash_command_interface;
  timeunit 1ns;
  timeprecision 1ps;

  import nfci_pkg::*;

  localparam int BLOCK_BYTES   = 4096;
  localparam int BLOCK_COUNT   = 16;
  localparam int LOCK_OFFSET   = 2;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int QUIET_ITEMS   = 200;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int ERASE_BUDGET  = 48;

  // Query table, first byte in the top bits.
  localparam logic [375:0] QUERY_BYTES =
    376'h5152590100310000000000_2736000007070A00040404_001802000500017F000002_50524931310A0000000101_003300;

  typedef enum logic [1:0] {MODE_ARRAY, MODE_PROGRAM, MODE_ERASE, MODE_LOCK} flash_mode_t;
  typedef enum logic [1:0] {VIEW_PLAIN, VIEW_STATUS, VIEW_ID, VIEW_QUERY} flash_view_t;

  typedef struct packed {
    logic        action;
    logic [15:0] address;
    logic [31:0] data;
    logic [2:0]  width;
  } bus_access_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  fault;
  } bus_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;

  // Flash model state.
  flash_mode_t flash_mode;
  flash_view_t shown_view;
  logic [15:0] status_addr;
  logic [7:0]  status_byte;
  logic        lock_bits [BLOCK_COUNT];
  logic [7:0]  flash_cells [0:65535];
  logic [7:0]  maker_code;
  logic [7:0]  part_code;

  bus_reply_t  bus_replies [$];
  bus_reply_t  awaited;
  int          mismatches = 0;
  int          items_sent = 0;
  int          erases_left = ERASE_BUDGET;
  int          cycle_count = 0;
  int          rx_hold = 0;
  bit          bursts_on = 1'b1;

  nor_flash_command_interface #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .BLOCK_COUNT(BLOCK_COUNT),
    .LOCK_OFFSET(LOCK_OFFSET)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Cycle limit guards against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_nor_flash_command_interface: done, errors");
      $finish;
    end
  end

  // Result side: random stall bursts while bursts are enabled.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      rx_hold <= $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Each reply item is checked against the oldest pending prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (bus_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply with nothing pending: read_data %h fault %0d",
                   m_tdata[31:0], m_tdata[33:32]);
      end else begin
        awaited = bus_replies.pop_front();
        if (m_tdata[31:0] !== awaited.read_data || m_tdata[33:32] !== awaited.fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply mismatch: read_data exp %h got %h, fault exp %0d got %0d",
                     awaited.read_data, m_tdata[31:0], awaited.fault, m_tdata[33:32]);
        end
      end
    end
  end

  // Model state after reset.
  task automatic reset_flash_model();
    flash_mode = MODE_ARRAY;
    shown_view = VIEW_PLAIN;
    status_addr = '0;
    status_byte = SR_READY;
    maker_code = 8'h89;
    part_code = 8'h18;
    foreach (lock_bits[k]) lock_bits[k] = 1'b0;
    foreach (flash_cells[k]) flash_cells[k] = 8'hFF;
  endtask

  // Byte seen by a read at one address, overlay first, then the array.
  function automatic logic [7:0] view_byte(input logic [15:0] a);
    int unsigned blk;
    int qi;
    blk = a / BLOCK_BYTES;
    case (shown_view)
      VIEW_STATUS: if (a == status_addr) return status_byte;
      VIEW_ID: begin
        if (a == 16'd0) return maker_code;
        if (a == 16'd1) return part_code;
        if (blk < BLOCK_COUNT && int'(a) - int'(blk) * BLOCK_BYTES == LOCK_OFFSET)
          return {7'b0, lock_bits[blk]};
      end
      VIEW_QUERY: begin
        if (a >= CFI_BASE && a < CFI_END) begin
          qi = int'(a - CFI_BASE);
          return QUERY_BYTES[(46 - qi) * 8 +: 8];
        end
      end
      default: ;
    endcase
    return flash_cells[a];
  endfunction

  task automatic show_status(input logic [15:0] a, input logic [7:0] sr);
    shown_view = VIEW_STATUS;
    status_addr = a;
    status_byte = sr;
  endtask

  // Works out the reply to one accepted access and updates the model.
  task automatic emulate_access(input bus_access_t it);
    int unsigned n, blk, i, j, top;
    logic [31:0] v, rd;
    logic [7:0]  cmd;
    logic [15:0] ai;
    logic [1:0]  flt;
    bit          blk_ok;
    bus_reply_t  r;
    n = it.width;
    if (n > 4) n = 4;
    v = it.data;
    if (n < 4) v = v & ((32'd1 << (8 * n)) - 32'd1);
    rd = '0;
    flt = FAULT_OK;
    cmd = v[7:0];
    blk = it.address / BLOCK_BYTES;
    blk_ok = blk < BLOCK_COUNT;
    if (!it.action) begin
      for (i = 0; i < n; i++) begin
        ai = it.address + i[15:0];
        rd[8 * i +: 8] = view_byte(ai);
      end
    end else begin
      case (flash_mode)
        MODE_PROGRAM: begin
          flash_mode = MODE_ARRAY;
          if (!blk_ok) begin
            flt = FAULT_RANGE;
          end else if (lock_bits[blk]) begin
            show_status(it.address, SR_PROG_LOCKED);
          end else begin
            // Cells can only be cleared, so the data is ANDed in.
            for (i = 0; i < n; i++) begin
              ai = it.address + i[15:0];
              flash_cells[ai] = flash_cells[ai] & v[8 * i +: 8];
            end
            show_status(it.address, SR_READY);
          end
        end
        MODE_ERASE: begin
          flash_mode = MODE_ARRAY;
          if (cmd == CMD_CONFIRM) begin
            if (!blk_ok) begin
              flt = FAULT_RANGE;
            end else if (lock_bits[blk]) begin
              show_status(it.address, SR_ERASE_LOCKED);
            end else begin
              top = blk * BLOCK_BYTES + BLOCK_BYTES;
              if (top > 65536) top = 65536;
              for (j = blk * BLOCK_BYTES; j < top; j++) flash_cells[j] = 8'hFF;
              show_status(it.address, SR_READY);
            end
          end
        end
        MODE_LOCK: begin
          flash_mode = MODE_ARRAY;
          if (cmd == CMD_LOCK_SET) begin
            if (!blk_ok) begin
              flt = FAULT_RANGE;
            end else begin
              lock_bits[blk] = 1'b1;
              show_status(it.address, SR_READY);
            end
          end else if (cmd == CMD_CONFIRM) begin
            foreach (lock_bits[k]) lock_bits[k] = 1'b0;
            show_status(it.address, SR_READY);
          end else begin
            shown_view = VIEW_PLAIN;
          end
        end
        default: begin
          case (cmd)
            CMD_READ_ARRAY: shown_view = VIEW_PLAIN;
            CMD_READ_ID:    shown_view = VIEW_ID;
            CMD_CFI_QUERY:  shown_view = VIEW_QUERY;
            CMD_READ_SR:    show_status(it.address, SR_READY);
            CMD_CLEAR_SR, CMD_SUSPEND, CMD_CONFIRM: ;
            CMD_PROGRAM, CMD_PROGRAM_A: flash_mode = MODE_PROGRAM;
            CMD_ERASE:      flash_mode = MODE_ERASE;
            CMD_LOCK: begin
              flash_mode = MODE_LOCK;
              show_status(it.address, SR_READY);
            end
            default:        flt = FAULT_CMD;
          endcase
        end
      endcase
    end
    r.read_data = rd;
    r.fault = flt;
    bus_replies = {bus_replies, r};
  endtask

  // Presents one item, with an optional idle burst first, and waits for acceptance.
  task automatic send_access(input bus_access_t it);
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, it.width, it.data, it.address};
    s_tuser <= it.action;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    emulate_access(it);
  endtask

  task automatic read_at(input logic [15:0] a, input logic [2:0] w);
    bus_access_t t;
    t.action = 1'b0;
    t.address = a;
    t.data = 32'($urandom);
    t.width = w;
    send_access(t);
  endtask

  // Erase confirms are rationed, since each one walks a whole block.
  task automatic write_at(input logic [15:0] a, input logic [31:0] d, input logic [2:0] w);
    bus_access_t t;
    if (flash_mode == MODE_ERASE && d[7:0] == CMD_CONFIRM && w != 3'd0) begin
      if (erases_left == 0) d[7:0] = 8'hD1;
      else erases_left--;
    end
    t.action = 1'b1;
    t.address = a;
    t.data = d;
    t.width = w;
    send_access(t);
  endtask

  function automatic logic [31:0] with_cmd(input logic [7:0] c);
    return {24'($urandom), c};
  endfunction

  // Lowers valid and waits until every reply is in and the block is quiet.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (bus_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MANUFACTURER) maker_code = val;
    else part_code = val;
  endtask

  function automatic int hot_block();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return 7;
      default: return BLOCK_COUNT - 1;
    endcase
  endfunction

  // Addresses cluster on a few blocks so that programmed cells are read back.
  function automatic logic [15:0] pick_address();
    int unsigned base;
    base = hot_block() * BLOCK_BYTES;
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'(32'hFFFC + $urandom_range(0, 3));
      2: return 16'(32'(CFI_BASE) - 4 + $urandom_range(0, 52));
      3: return 16'(base + $urandom_range(0, 3));
      4: return 16'(base + BLOCK_BYTES - 1 - $urandom_range(0, 3));
      default: return 16'(base + $urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [2:0] pick_width();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: return 3'd1;
      6, 7, 8, 9, 10:   return 3'd2;
      11, 12, 13, 14:   return 3'd4;
      15:               return 3'd0;
      16, 17:           return 3'd3;
      default:          return 3'(5 + $urandom_range(0, 2));
    endcase
  endfunction

  // Reads straight after reset, including wrap past the top and odd widths.
  task automatic test_power_on_reads();
    read_at(16'hFFFE, 3'd4);
    read_at(16'h0100, 3'd0);
    read_at(16'h0300, 3'd7);
  endtask

  // Identifier view with register values read live.
  task automatic test_identifier_view();
    write_at(16'h0000, with_cmd(CMD_READ_ID), 3'd4);
    read_at(16'h0000, 3'd4);
    read_at(16'h1002, 3'd1);
    settle();
    write_register(CFG_MANUFACTURER, 8'h00);
    write_register(CFG_DEVICE, 8'hFF);
    read_at(16'h0000, 3'd2);
  endtask

  // Query table window, both edges.
  task automatic test_query_view();
    write_at(16'h0000, with_cmd(CMD_CFI_QUERY), 3'd1);
    read_at(16'h000E, 3'd4);
    read_at(16'h003D, 3'd4);
  endtask

  // Program across the top of the array, erase, and a broken erase setup.
  task automatic test_program_and_erase();
    write_at(16'h0000, with_cmd(CMD_PROGRAM), 3'd1);
    write_at(16'hFFFF, 32'h12345678, 3'd4);
    read_at(16'hFFFE, 3'd4);
    write_at(16'h0000, with_cmd(CMD_ERASE), 3'd1);
    write_at(16'h0000, with_cmd(CMD_CONFIRM), 3'd1);
    write_at(16'h0000, with_cmd(CMD_ERASE), 3'd1);
    write_at(16'h0000, 32'h00000055, 3'd1);
  endtask

  // Lock one block, hit it with program and erase, then clear all locks.
  task automatic test_block_locking();
    write_at(16'h2000, with_cmd(CMD_LOCK), 3'd1);
    write_at(16'h2000, with_cmd(CMD_LOCK_SET), 3'd1);
    write_at(16'h2000, with_cmd(CMD_PROGRAM_A), 3'd1);
    write_at(16'h2004, 32'h00000000, 3'd4);
    write_at(16'h2000, with_cmd(CMD_ERASE), 3'd1);
    write_at(16'h2000, with_cmd(CMD_CONFIRM), 3'd1);
    write_at(16'h0000, with_cmd(CMD_READ_ID), 3'd1);
    read_at(16'h2002, 3'd1);
    write_at(16'h0000, with_cmd(CMD_LOCK), 3'd1);
    write_at(16'h0000, with_cmd(CMD_CONFIRM), 3'd1);
    write_at(16'h0000, with_cmd(CMD_LOCK), 3'd1);
    write_at(16'h0000, 32'h00000033, 3'd1);
  endtask

  // Unknown command and the commands that do nothing.
  task automatic test_plain_commands();
    write_at(16'h0000, 32'hFFFFFF00, 3'd4);
    write_at(16'h0000, with_cmd(CMD_CLEAR_SR), 3'd1);
    write_at(16'h0000, with_cmd(CMD_SUSPEND), 3'd1);
    write_at(16'h0000, with_cmd(CMD_CONFIRM), 3'd1);
  endtask

  // One short random command sequence, mostly well formed.
  task automatic random_sequence();
    logic [15:0] a;
    logic [7:0]  c;
    a = pick_address();
    case ($urandom_range(0, 11))
      0, 1: repeat ($urandom_range(1, 4)) read_at(pick_address(), pick_width());
      2, 3: begin
        case ($urandom_range(0, 3))
          0: c = CMD_READ_ARRAY;
          1: c = CMD_READ_ID;
          2: c = CMD_CFI_QUERY;
          default: c = CMD_READ_SR;
        endcase
        write_at(a, with_cmd(c), pick_width());
        repeat ($urandom_range(1, 3)) read_at(pick_address(), pick_width());
      end
      4, 5: begin
        write_at(pick_address(), with_cmd($urandom_range(0, 1) ? CMD_PROGRAM : CMD_PROGRAM_A),
                 pick_width());
        write_at(a, 32'($urandom), pick_width());
        read_at(a, pick_width());
        if ($urandom_range(0, 1)) begin
          write_at(a, with_cmd(CMD_READ_ARRAY), 3'd1);
          read_at(a, pick_width());
        end
      end
      6: begin
        write_at(a, with_cmd(CMD_ERASE), pick_width());
        write_at(a, with_cmd($urandom_range(0, 4) != 0 ? CMD_CONFIRM : 8'($urandom)),
                 pick_width());
        read_at(a, pick_width());
      end
      7: begin
        write_at(a, with_cmd(CMD_LOCK), pick_width());
        case ($urandom_range(0, 5))
          0, 1, 2: c = CMD_LOCK_SET;
          3, 4:    c = CMD_CONFIRM;
          default: c = 8'($urandom);
        endcase
        write_at(a, with_cmd(c), pick_width());
        if ($urandom_range(0, 1)) begin
          write_at(a, with_cmd(CMD_READ_ID), 3'd1);
          read_at(16'((a / BLOCK_BYTES) * BLOCK_BYTES + LOCK_OFFSET), pick_width());
        end
      end
      8: write_at(pick_address(), 32'($urandom), pick_width());
      9: begin
        case ($urandom_range(0, 2))
          0: c = CMD_CLEAR_SR;
          1: c = CMD_SUSPEND;
          default: c = CMD_CONFIRM;
        endcase
        write_at(a, with_cmd(c), pick_width());
      end
      default: read_at(a, pick_width());
    endcase
  endtask

  // Random traffic in four phases, each with its own identifier codes.
  task automatic test_random_traffic();
    int start, seg, seg_end, quiet_from;
    start = items_sent;
    quiet_from = start + RANDOM_ITEMS - QUIET_ITEMS;
    for (seg = 0; seg < 4; seg++) begin
      settle();
      case (seg)
        0: begin
          write_register(CFG_MANUFACTURER, 8'h89);
          write_register(CFG_DEVICE, 8'h18);
        end
        1: begin
          write_register(CFG_MANUFACTURER, 8'hFF);
          write_register(CFG_DEVICE, 8'h00);
        end
        default: begin
          write_register(CFG_MANUFACTURER, 8'($urandom));
          write_register(CFG_DEVICE, 8'($urandom));
        end
      endcase
      seg_end = start + (seg + 1) * RANDOM_ITEMS / 4;
      while (items_sent < seg_end) begin
        if (items_sent >= quiet_from) bursts_on = 1'b0;
        else if ($urandom_range(0, 15) == 0) bursts_on = !bursts_on;
        random_sequence();
      end
    end
  endtask

  // Test sequence.
  initial begin
    reset_flash_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_power_on_reads();
    test_identifier_view();
    test_query_view();
    test_program_and_erase();
    test_block_locking();
    test_plain_commands();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("tb_nor_flash_command_interface: done, clean");
    end else begin
      $display("tb_nor_flash_command_interface: done, errors");
    end
    $finish;
  end

endmodule
